// ===== rtl/c8ic_pkg.sv =====
// Shared types, constants and a helper function for the CHIP-8 instruction core.
package c8ic_pkg;

    localparam int MEM_BYTES_DEF   = 4096;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int DISP_W          = 64;
    localparam int DISP_H          = 32;
    localparam int FONT_BYTES      = 80;

    localparam logic [11:0] PC_RESET    = 12'h200;
    localparam logic [7:0]  TIMER_RESET = 8'd60;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_EXEC  = 2'd1;
    localparam logic [1:0] MODE_PIXEL = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // datapath micro-operations
    localparam logic [4:0] U_NOP       = 5'd0;
    localparam logic [4:0] U_SWEEP     = 5'd1;
    localparam logic [4:0] U_CAPTURE   = 5'd2;
    localparam logic [4:0] U_MOD       = 5'd3;
    localparam logic [4:0] U_MEM_WR_IN = 5'd4;
    localparam logic [4:0] U_MEM_RD    = 5'd5;
    localparam logic [4:0] U_RV_MEM    = 5'd6;
    localparam logic [4:0] U_FB_PIX    = 5'd7;
    localparam logic [4:0] U_RV_PIX    = 5'd8;
    localparam logic [4:0] U_OP_HI     = 5'd9;
    localparam logic [4:0] U_OP_LO     = 5'd10;
    localparam logic [4:0] U_VRD_Y     = 5'd11;
    localparam logic [4:0] U_VRD_0     = 5'd12;
    localparam logic [4:0] U_EXEC      = 5'd13;
    localparam logic [4:0] U_CLR_RD    = 5'd14;
    localparam logic [4:0] U_CLR_WR    = 5'd15;
    localparam logic [4:0] U_DRW_RD    = 5'd16;
    localparam logic [4:0] U_DRW_XOR   = 5'd17;
    localparam logic [4:0] U_WR_F      = 5'd18;
    localparam logic [4:0] U_BCD_WR    = 5'd19;
    localparam logic [4:0] U_RET       = 5'd20;
    localparam logic [4:0] U_FIN       = 5'd21;
    localparam logic [4:0] U_OUT       = 5'd22;

    // address reduction source
    localparam logic [1:0] MS_ADDR = 2'd0;
    localparam logic [1:0] MS_PC   = 2'd1;
    localparam logic [1:0] MS_IDX  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] address;
        logic [7:0]  data_byte;
        logic [15:0] key_state;
        logic [7:0]  random_byte;
    } item_t;

    typedef struct packed {
        logic [11:0] pc_now;
        logic [15:0] opcode_now;
        logic        display_changed;
        logic        sound_on;
        logic        bad_opcode;
        logic [7:0]  read_value;
    } result_t;

    typedef struct packed {
        logic [4:0] uop;
        logic [1:0] mod_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] op;
        logic [4:0]  cnt;
        logic        mod_busy;
        logic        sweep_last;
        logic        out_full;
        logic        sp_empty;
    } stat_t;

    // decimal digit of v: sel 0 hundreds, 1 tens, 2 units
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [13:0] ph;
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] pt;
        logic [3:0]  t;
        logic [3:0]  o;
        ph = 14'(v) * 14'd41;
        h  = ph[13:12];
        r  = 7'(v - 8'(h) * 8'd100);
        pt = 15'(r) * 15'd205;
        t  = pt[14:11];
        o  = 4'(r - 7'(t) * 7'd10);
        case (sel)
            2'd0:    bcd_digit = 8'(h);
            2'd1:    bcd_digit = 8'(t);
            default: bcd_digit = 8'(o);
        endcase
    endfunction

endpackage

// ===== rtl/chip8_instruction_core_top.sv =====
// Top level of the CHIP-8 instruction core.
// One transfer in gives one transfer out; items are handled one at a time. After reset the
// core writes the font and zeros into all of main memory (clearing the display and V
// registers alongside) before it takes its first item; the start address register may be
// written meanwhile. Every item and instruction memory address goes through a shared
// remainder unit (reciprocal multiply and one correction); each access waits until the
// unit is idle. An instruction fetches its two bytes, reads V[x], V[y] and V0, executes
// and writes VF where needed. A clear adds one read and one write per display row, a draw
// adds a reduction, read and XOR write per sprite row plus the VF write, and FX33 a
// reduction and a write per digit. A finished result waits in the last state while the
// previous result is not taken; the result register frees the input side while a result
// waits to be taken.
module chip8_instruction_core_top
    import c8ic_pkg::*;
#(
    parameter int MEM_BYTES   = MEM_BYTES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        cfg_write,
    input  logic [11:0] cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    c8ic_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    c8ic_dp #(
        .MEM_BYTES   (MEM_BYTES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .cfg_write    (cfg_write),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== rtl/c8ic_mod.sv =====
// Two-stage reduction of a 17-bit address modulo the memory size.
module c8ic_mod
    import c8ic_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF,
    localparam int AW = $clog2(MEM_BYTES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [16:0]   value,
    output logic          busy,
    output logic [AW-1:0] result
);

    // quotient estimate by reciprocal multiply, low by at most one
    localparam int RSH   = 29;
    localparam int RECIP = (1 << RSH) / MEM_BYTES;

    logic [16:0]   v_reg, v_next;
    logic [8:0]    q_reg, q_next;
    logic [AW-1:0] r_reg, r_next;
    logic          k_reg, k_next;
    logic          busy_reg, busy_next;
    logic [37:0]   prod;
    logic [21:0]   qm;
    logic [17:0]   r0, r1;

    assign prod = 38'(v_reg) * 38'(RECIP);
    assign qm   = 22'(q_reg) * 22'(MEM_BYTES);
    assign r0   = {1'b0, v_reg} - qm[17:0];
    assign r1   = (r0 >= 18'(MEM_BYTES)) ? r0 - 18'(MEM_BYTES) : r0;

    always_comb
    begin
        v_next    = v_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        if (start)
        begin
            v_next    = value;
            k_next    = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!k_reg)
            begin
                q_next = prod[37:29];
                k_next = 1'b1;
            end
            else
            begin
                r_next    = r1[AW-1:0];
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy   = busy_reg;
    assign result = r_reg;

endmodule

// ===== rtl/c8ic_dp.sv =====
// Datapath: memories, machine registers, instruction execution and result register.
module c8ic_dp
    import c8ic_pkg::*;
#(
    parameter int MEM_BYTES   = MEM_BYTES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  item_t       item,
    input  logic        cfg_write,
    input  logic [11:0] cfg_wdata,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int RW  = $clog2(DISP_H);

    logic [7:0]        mem  [MEM_BYTES];
    logic [DISP_W-1:0] fb   [DISP_H];
    logic [7:0]        vregs [16];
    logic [11:0]       stk  [STACK_DEPTH];

    item_t       item_reg, item_next;
    logic [15:0] op_reg, op_next;
    logic [11:0] pc_reg, pc_next;
    logic [11:0] npc_reg, npc_next;
    logic [15:0] i_reg, i_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  st_reg, st_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [7:0]  vx_reg, vx_next;
    logic [7:0]  vy_reg, vy_next;
    logic        flag_reg, flag_next;
    logic        changed_reg, changed_next;
    logic        bad_reg, bad_next;
    logic [7:0]  rv_reg, rv_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    logic [7:0]        v_rd_reg;
    logic [7:0]        mem_rd_reg;
    logic [DISP_W-1:0] fb_rd_reg;
    logic [11:0]       stk_rd_reg;

    logic [16:0]   mod_value;
    logic          mod_busy;
    logic [AW-1:0] mod_res;

    logic [3:0]  x, y, n;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [11:0] pc2, pc4;
    logic [8:0]  sum9;
    logic        keybit;
    logic        sp_empty, sp_full;
    logic [SPW-1:0] spm1;
    logic [RW-1:0]  draw_row;
    logic [DISP_W-1:0] mask;

    logic [11:0] e_next;
    logic        e_vwe;
    logic [7:0]  e_vwd;
    logic        e_flag;
    logic [15:0] e_i;
    logic [7:0]  e_dt, e_st;
    logic        e_bad, e_push, e_pop;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          fb_we, fb_re;
    logic [RW-1:0] fb_wa, fb_ra;
    logic [DISP_W-1:0] fb_wd;
    logic          v_we, v_re;
    logic [3:0]    v_wa, v_ra;
    logic [7:0]    v_wd;

    assign x   = op_reg[11:8];
    assign y   = op_reg[7:4];
    assign n   = op_reg[3:0];
    assign nn  = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;
    assign sum9   = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign keybit = item_reg.key_state[vx_reg[3:0]];
    assign sp_empty = (sp_reg == '0);
    assign sp_full  = (sp_reg == SPW'(STACK_DEPTH));
    assign spm1     = sp_reg - 1'b1;
    assign draw_row = vy_reg[RW-1:0] + cnt_reg[RW-1:0];

    always_comb
    begin
        case (cmd.mod_sel)
            MS_ADDR: mod_value = 17'(item_reg.address);
            MS_PC:   mod_value = 17'(pc_reg) + 17'(cnt_reg);
            MS_IDX:  mod_value = {1'b0, i_reg} + 17'(cnt_reg);
            default: mod_value = '0;
        endcase
    end

    c8ic_mod #(.MEM_BYTES(MEM_BYTES)) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.uop == U_MOD),
        .value  (mod_value),
        .busy   (mod_busy),
        .result (mod_res)
    );

    // sprite row placed on the display row, wrapping horizontally
    always_comb
    begin
        mask = '0;
        for (int b = 0; b < 8; b++)
        begin
            mask[vx_reg[5:0] + 6'(b)] = mem_rd_reg[3'(7 - b)];
        end
    end

    always_comb
    begin
        e_next = pc2;
        e_vwe  = 1'b0;
        e_vwd  = '0;
        e_flag = flag_reg;
        e_i    = i_reg;
        e_dt   = dt_reg;
        e_st   = st_reg;
        e_bad  = 1'b0;
        e_push = 1'b0;
        e_pop  = 1'b0;
        case (op_reg[15:12])
            4'h0:
            begin
                if (op_reg == 16'h00EE)
                begin
                    e_pop = !sp_empty;
                end
                else if (op_reg != 16'h00E0)
                begin
                    e_bad = 1'b1;
                end
            end
            4'h1: e_next = nnn;
            4'h2:
            begin
                e_push = !sp_full;
                e_next = nnn;
            end
            4'h3: if (vx_reg == nn) e_next = pc4;
            4'h4: if (vx_reg != nn) e_next = pc4;
            4'h5:
            begin
                if (n != 4'h0)
                    e_bad = 1'b1;
                else if (vx_reg == vy_reg)
                    e_next = pc4;
            end
            4'h6:
            begin
                e_vwe = 1'b1;
                e_vwd = nn;
            end
            4'h7:
            begin
                e_vwe = 1'b1;
                e_vwd = vx_reg + nn;
            end
            4'h8:
            begin
                e_vwe = 1'b1;
                case (n)
                    4'h0: e_vwd = vy_reg;
                    4'h1: e_vwd = vx_reg | vy_reg;
                    4'h2: e_vwd = vx_reg & vy_reg;
                    4'h3: e_vwd = vx_reg ^ vy_reg;
                    4'h4:
                    begin
                        e_vwd  = sum9[7:0];
                        e_flag = sum9[8];
                    end
                    4'h5:
                    begin
                        e_vwd  = vx_reg - vy_reg;
                        e_flag = (vx_reg >= vy_reg);
                    end
                    4'h6:
                    begin
                        e_vwd  = {1'b0, vx_reg[7:1]};
                        e_flag = vx_reg[0];
                    end
                    4'h7:
                    begin
                        e_vwd  = vy_reg - vx_reg;
                        e_flag = (vy_reg >= vx_reg);
                    end
                    4'hE:
                    begin
                        e_vwd  = {vx_reg[6:0], 1'b0};
                        e_flag = vx_reg[7];
                    end
                    default:
                    begin
                        e_vwe = 1'b0;
                        e_bad = 1'b1;
                    end
                endcase
            end
            4'h9:
            begin
                if (n != 4'h0)
                    e_bad = 1'b1;
                else if (vx_reg != vy_reg)
                    e_next = pc4;
            end
            4'hA: e_i = 16'(nnn);
            4'hB: e_next = 12'(v_rd_reg) + nnn;
            4'hC:
            begin
                e_vwe = 1'b1;
                e_vwd = item_reg.random_byte & nn;
            end
            4'hD: ;
            4'hE:
            begin
                if (nn == 8'h9E)
                begin
                    if (keybit) e_next = pc4;
                end
                else if (nn == 8'hA1)
                begin
                    if (!keybit) e_next = pc4;
                end
                else
                begin
                    e_bad = 1'b1;
                end
            end
            default:
            begin
                case (nn)
                    8'h07:
                    begin
                        e_vwe = 1'b1;
                        e_vwd = dt_reg;
                    end
                    8'h0A, 8'h55, 8'h65, 8'h33: ;
                    8'h15: e_dt = vx_reg;
                    8'h18: e_st = vx_reg;
                    8'h1E: e_i  = i_reg + 16'(vx_reg);
                    8'h29: e_i  = 16'(vx_reg[3:0]) * 16'd5;
                    default: e_bad = 1'b1;
                endcase
            end
        endcase
    end

    always_comb
    begin
        item_next      = item_reg;
        op_next        = op_reg;
        pc_next        = pc_reg;
        npc_next       = npc_reg;
        i_next         = i_reg;
        sp_next        = sp_reg;
        dt_next        = dt_reg;
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        flag_next      = flag_reg;
        changed_next   = changed_reg;
        bad_next       = bad_reg;
        rv_next        = rv_reg;
        sweep_next     = sweep_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (cmd.uop)
            U_SWEEP: sweep_next = sweep_reg + 1'b1;
            U_CAPTURE:
            begin
                item_next    = item;
                op_next      = '0;
                cnt_next     = '0;
                flag_next    = 1'b0;
                changed_next = 1'b0;
                bad_next     = 1'b0;
                rv_next      = '0;
            end
            U_RV_MEM: rv_next = mem_rd_reg;
            U_RV_PIX: rv_next = 8'(fb_rd_reg[item_reg.address[5:0]]);
            U_OP_HI:
            begin
                op_next[15:8] = mem_rd_reg;
                cnt_next      = 5'd1;
            end
            U_OP_LO:
            begin
                op_next[7:0] = mem_rd_reg;
                cnt_next     = '0;
            end
            U_VRD_Y: vx_next = v_rd_reg;
            U_VRD_0: vy_next = v_rd_reg;
            U_EXEC:
            begin
                npc_next  = e_next;
                i_next    = e_i;
                dt_next   = e_dt;
                st_next   = e_st;
                bad_next  = e_bad;
                flag_next = e_flag;
                if (e_push)
                    sp_next = sp_reg + 1'b1;
                else if (e_pop)
                    sp_next = spm1;
            end
            U_CLR_WR:
            begin
                if (fb_rd_reg != '0)
                    changed_next = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            U_DRW_XOR:
            begin
                if (mask != '0)
                    changed_next = 1'b1;
                if ((fb_rd_reg & mask) != '0)
                    flag_next = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            U_BCD_WR: cnt_next = cnt_reg + 1'b1;
            U_RET:    npc_next = stk_rd_reg + 12'd2;
            U_FIN:
            begin
                pc_next = npc_reg;
                if (dt_reg != '0)
                    dt_next = dt_reg - 1'b1;
                if (st_reg != '0)
                    st_next = st_reg - 1'b1;
            end
            U_OUT:
            begin
                res_valid_next           = 1'b1;
                res_next.pc_now          = pc_reg;
                res_next.opcode_now      = op_reg;
                res_next.display_changed = changed_reg;
                res_next.sound_on        = (st_reg != '0);
                res_next.bad_opcode      = bad_reg;
                res_next.read_value      = rv_reg;
            end
            default: ;
        endcase
        if (cfg_write)
        begin
            pc_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_RESET;
            i_reg         <= '0;
            sp_reg        <= '0;
            dt_reg        <= TIMER_RESET;
            st_reg        <= TIMER_RESET;
            cnt_reg       <= '0;
            sweep_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            dt_reg        <= dt_next;
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            sweep_reg     <= sweep_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        op_reg      <= op_next;
        npc_reg     <= npc_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        flag_reg    <= flag_next;
        changed_reg <= changed_next;
        bad_reg     <= bad_next;
        rv_reg      <= rv_next;
        res_reg     <= res_next;
    end

    // main memory
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = mod_res;
        mem_wd = item_reg.data_byte;
        mem_re = (cmd.uop == U_MEM_RD) || (cmd.uop == U_DRW_RD);
        case (cmd.uop)
            U_SWEEP:
            begin
                mem_we = 1'b1;
                mem_wa = sweep_reg;
                mem_wd = (sweep_reg < AW'(FONT_BYTES)) ? FONT[sweep_reg[6:0]] : 8'h00;
            end
            U_MEM_WR_IN: mem_we = 1'b1;
            U_BCD_WR:
            begin
                mem_we = 1'b1;
                mem_wd = bcd_digit(vx_reg, cnt_reg[1:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_rd_reg <= mem[mod_res];
    end

    // frame buffer, one display row per entry
    always_comb
    begin
        fb_we = 1'b0;
        fb_wa = cnt_reg[RW-1:0];
        fb_wd = '0;
        fb_re = 1'b1;
        fb_ra = cnt_reg[RW-1:0];
        case (cmd.uop)
            U_SWEEP:
            begin
                fb_we = 1'b1;
                fb_wa = sweep_reg[RW-1:0];
            end
            U_CLR_WR: fb_we = 1'b1;
            U_DRW_XOR:
            begin
                fb_we = 1'b1;
                fb_wa = draw_row;
                fb_wd = fb_rd_reg ^ mask;
            end
            U_FB_PIX: fb_ra = item_reg.address[10:6];
            U_CLR_RD: fb_ra = cnt_reg[RW-1:0];
            U_DRW_RD: fb_ra = draw_row;
            default:  fb_re = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
            fb[fb_wa] <= fb_wd;
        if (fb_re)
            fb_rd_reg <= fb[fb_ra];
    end

    // V registers
    always_comb
    begin
        v_we = 1'b0;
        v_wa = x;
        v_wd = e_vwd;
        v_re = 1'b1;
        v_ra = x;
        case (cmd.uop)
            U_SWEEP:
            begin
                v_we = 1'b1;
                v_wa = sweep_reg[3:0];
                v_wd = '0;
            end
            U_EXEC: v_we = e_vwe;
            U_WR_F:
            begin
                v_we = 1'b1;
                v_wa = 4'hF;
                v_wd = 8'(flag_reg);
            end
            U_OP_LO: v_ra = x;
            U_VRD_Y: v_ra = y;
            U_VRD_0: v_ra = 4'h0;
            default: v_re = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vregs[v_wa] <= v_wd;
        if (v_re)
            v_rd_reg <= vregs[v_ra];
    end

    // return stack
    always_ff @(posedge clk)
    begin
        if ((cmd.uop == U_EXEC) && e_push)
            stk[sp_reg[SIW-1:0]] <= pc_reg;
        if ((cmd.uop == U_EXEC) && e_pop)
            stk_rd_reg <= stk[spm1[SIW-1:0]];
    end

    assign stat.mode       = item_reg.mode;
    assign stat.op         = op_reg;
    assign stat.cnt        = cnt_reg;
    assign stat.mod_busy   = mod_busy;
    assign stat.sweep_last = (sweep_reg == AW'(MEM_BYTES - 1));
    assign stat.out_full   = res_valid_reg && !result_ready;
    assign stat.sp_empty   = sp_empty;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/c8ic_ctrl.sv =====
// Controller state machine sequencing the datapath for each transfer.
module c8ic_ctrl
    import c8ic_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DISP   = 5'd2;
    localparam logic [4:0] S_AMW    = 5'd3;
    localparam logic [4:0] S_RDW    = 5'd4;
    localparam logic [4:0] S_PIXW   = 5'd5;
    localparam logic [4:0] S_FW     = 5'd6;
    localparam logic [4:0] S_FHI    = 5'd7;
    localparam logic [4:0] S_FLM    = 5'd8;
    localparam logic [4:0] S_FLW    = 5'd9;
    localparam logic [4:0] S_FLO    = 5'd10;
    localparam logic [4:0] S_RVY    = 5'd11;
    localparam logic [4:0] S_RV0    = 5'd12;
    localparam logic [4:0] S_EXEC   = 5'd13;
    localparam logic [4:0] S_CLR_RD = 5'd14;
    localparam logic [4:0] S_CLR_WR = 5'd15;
    localparam logic [4:0] S_DRW_M  = 5'd16;
    localparam logic [4:0] S_DRW_W  = 5'd17;
    localparam logic [4:0] S_DRW_X  = 5'd18;
    localparam logic [4:0] S_WRF    = 5'd19;
    localparam logic [4:0] S_BCD_M  = 5'd20;
    localparam logic [4:0] S_BCD_W  = 5'd21;
    localparam logic [4:0] S_RET    = 5'd22;
    localparam logic [4:0] S_FIN    = 5'd23;
    localparam logic [4:0] S_DONE   = 5'd24;

    logic [4:0] state_reg, state_next;
    logic [3:0] hi, n;
    logic [7:0] nn;

    assign hi = stat.op[15:12];
    assign n  = stat.op[3:0];
    assign nn = stat.op[7:0];

    always_comb
    begin
        state_next  = state_reg;
        cmd.uop     = U_NOP;
        cmd.mod_sel = MS_ADDR;
        item_ready  = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.uop = U_SWEEP;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.uop    = U_CAPTURE;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.mode)
                    MODE_PIXEL:
                    begin
                        cmd.uop    = U_FB_PIX;
                        state_next = S_PIXW;
                    end
                    MODE_EXEC:
                    begin
                        cmd.uop     = U_MOD;
                        cmd.mod_sel = MS_PC;
                        state_next  = S_FW;
                    end
                    default:
                    begin
                        cmd.uop    = U_MOD;
                        state_next = S_AMW;
                    end
                endcase
            end
            S_AMW:
            begin
                if (!stat.mod_busy)
                begin
                    if (stat.mode == MODE_LOAD)
                    begin
                        cmd.uop    = U_MEM_WR_IN;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.uop    = U_MEM_RD;
                        state_next = S_RDW;
                    end
                end
            end
            S_RDW:
            begin
                cmd.uop    = U_RV_MEM;
                state_next = S_DONE;
            end
            S_PIXW:
            begin
                cmd.uop    = U_RV_PIX;
                state_next = S_DONE;
            end
            S_FW:
            begin
                if (!stat.mod_busy)
                begin
                    cmd.uop    = U_MEM_RD;
                    state_next = S_FHI;
                end
            end
            S_FHI:
            begin
                cmd.uop    = U_OP_HI;
                state_next = S_FLM;
            end
            S_FLM:
            begin
                cmd.uop     = U_MOD;
                cmd.mod_sel = MS_PC;
                state_next  = S_FLW;
            end
            S_FLW:
            begin
                if (!stat.mod_busy)
                begin
                    cmd.uop    = U_MEM_RD;
                    state_next = S_FLO;
                end
            end
            S_FLO:
            begin
                cmd.uop    = U_OP_LO;
                state_next = S_RVY;
            end
            S_RVY:
            begin
                cmd.uop    = U_VRD_Y;
                state_next = S_RV0;
            end
            S_RV0:
            begin
                cmd.uop    = U_VRD_0;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.uop = U_EXEC;
                if (stat.op == 16'h00E0)
                    state_next = S_CLR_RD;
                else if ((stat.op == 16'h00EE) && !stat.sp_empty)
                    state_next = S_RET;
                else if (hi == 4'hD)
                    state_next = S_DRW_M;
                else if ((hi == 4'hF) && (nn == 8'h33))
                    state_next = S_BCD_M;
                else if ((hi == 4'h8) && (n inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE}))
                    state_next = S_WRF;
                else
                    state_next = S_FIN;
            end
            S_CLR_RD:
            begin
                cmd.uop    = U_CLR_RD;
                state_next = S_CLR_WR;
            end
            S_CLR_WR:
            begin
                cmd.uop    = U_CLR_WR;
                state_next = (stat.cnt == 5'd31) ? S_FIN : S_CLR_RD;
            end
            S_DRW_M:
            begin
                if (stat.cnt == {1'b0, n})
                begin
                    state_next = S_WRF;
                end
                else
                begin
                    cmd.uop     = U_MOD;
                    cmd.mod_sel = MS_IDX;
                    state_next  = S_DRW_W;
                end
            end
            S_DRW_W:
            begin
                if (!stat.mod_busy)
                begin
                    cmd.uop    = U_DRW_RD;
                    state_next = S_DRW_X;
                end
            end
            S_DRW_X:
            begin
                cmd.uop    = U_DRW_XOR;
                state_next = S_DRW_M;
            end
            S_WRF:
            begin
                cmd.uop    = U_WR_F;
                state_next = S_FIN;
            end
            S_BCD_M:
            begin
                cmd.uop     = U_MOD;
                cmd.mod_sel = MS_IDX;
                state_next  = S_BCD_W;
            end
            S_BCD_W:
            begin
                if (!stat.mod_busy)
                begin
                    cmd.uop    = U_BCD_WR;
                    state_next = (stat.cnt == 5'd2) ? S_FIN : S_BCD_M;
                end
            end
            S_RET:
            begin
                cmd.uop    = U_RET;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.uop    = U_FIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_full)
                begin
                    cmd.uop    = U_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

endmodule

// ===== test/chip8_instruction_core_top_test.sv =====
// Self-checking testbench for the CHIP-8 instruction core: program loads, execution and reads.
`timescale 1ns / 100ps

module chip8_instruction_core_top_test;
    import c8ic_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0] SK_DOWN = 8'h9E;
    localparam logic [7:0] SK_UP = 8'hA1;
    localparam logic [7:0] F_GET_DT = 8'h07;
    localparam logic [7:0] F_WAIT_KEY = 8'h0A;
    localparam logic [7:0] F_SET_DT = 8'h15;
    localparam logic [7:0] F_SET_ST = 8'h18;
    localparam logic [7:0] F_ADD_I = 8'h1E;
    localparam logic [7:0] F_GLYPH = 8'h29;
    localparam logic [7:0] F_BCD = 8'h33;
    localparam logic [7:0] F_STORE = 8'h55;
    localparam logic [7:0] F_LOAD = 8'h65;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_write = 1'b0;
    logic [11:0] cfg_wdata = '0;

    chip8_instruction_core_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_wdata(cfg_wdata)
    );

    // core state as predicted
    logic [7:0] mem [4096];
    logic [7:0] vreg [16];
    logic [15:0] ireg;
    logic [11:0] pc;
    logic [11:0] ret_stack [16];
    int sp;
    logic fb [2048];
    logic [7:0] delay_t;
    logic [7:0] sound_t;

    item_t pending_items [$];
    result_t expected_results [$];
    int errors = 0;
    int cycles = 0;
    int n_items = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    logic in_taken = 1'b0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic result_t run_core(item_t it);
        result_t r;
        logic [15:0] op;
        logic [3:0] x, y, n;
        logic [7:0] nn, vx, vy, row;
        logic [11:0] nnn, nxt;
        logic [8:0] sum;
        logic f;
        int py, px;
        r = '0;
        case (it.mode)
            MODE_LOAD: mem[it.address] = it.data_byte;
            MODE_PIXEL: r.read_value = {7'd0, fb[it.address[10:0]]};
            MODE_READ: r.read_value = mem[it.address];
            default:
            begin
                op = {mem[pc], mem[12'(pc + 12'd1)]};
                x = op[11:8];
                y = op[7:4];
                n = op[3:0];
                nn = op[7:0];
                nnn = op[11:0];
                vx = vreg[x];
                vy = vreg[y];
                nxt = pc + 12'd2;
                case (op[15:12])
                    4'h0:
                    begin
                        if (op == OP_CLS)
                        begin
                            for (int i = 0; i < 2048; i++)
                            begin
                                if (fb[i])
                                    r.display_changed = 1'b1;
                                fb[i] = 1'b0;
                            end
                        end
                        else if (op == OP_RET)
                        begin
                            if (sp > 0)
                            begin
                                sp--;
                                nxt = ret_stack[sp] + 12'd2;
                            end
                        end
                        else
                            r.bad_opcode = 1'b1;
                    end
                    4'h1: nxt = nnn;
                    4'h2:
                    begin
                        if (sp < 16)
                        begin
                            ret_stack[sp] = pc;
                            sp++;
                        end
                        nxt = nnn;
                    end
                    4'h3: if (vx == nn) nxt = pc + 12'd4;
                    4'h4: if (vx != nn) nxt = pc + 12'd4;
                    4'h5:
                    begin
                        if (n != 0) r.bad_opcode = 1'b1;
                        else if (vx == vy) nxt = pc + 12'd4;
                    end
                    4'h6: vreg[x] = nn;
                    4'h7: vreg[x] = vx + nn;
                    4'h8:
                    begin
                        case (n)
                            4'h0: vreg[x] = vy;
                            4'h1: vreg[x] = vx | vy;
                            4'h2: vreg[x] = vx & vy;
                            4'h3: vreg[x] = vx ^ vy;
                            4'h4:
                            begin
                                sum = {1'b0, vx} + {1'b0, vy};
                                vreg[x] = sum[7:0];
                                vreg[15] = {7'd0, sum[8]};
                            end
                            4'h5:
                            begin
                                vreg[x] = vx - vy;
                                vreg[15] = {7'd0, vx >= vy};
                            end
                            4'h6:
                            begin
                                vreg[x] = vx >> 1;
                                vreg[15] = {7'd0, vx[0]};
                            end
                            4'h7:
                            begin
                                vreg[x] = vy - vx;
                                vreg[15] = {7'd0, vy >= vx};
                            end
                            4'hE:
                            begin
                                vreg[x] = vx << 1;
                                vreg[15] = {7'd0, vx[7]};
                            end
                            default: r.bad_opcode = 1'b1;
                        endcase
                    end
                    4'h9:
                    begin
                        if (n != 0) r.bad_opcode = 1'b1;
                        else if (vx != vy) nxt = pc + 12'd4;
                    end
                    4'hA: ireg = {4'd0, nnn};
                    4'hB: nxt = 12'(vreg[0]) + nnn;
                    4'hC: vreg[x] = it.random_byte & nn;
                    4'hD:
                    begin
                        f = 1'b0;
                        for (int rr = 0; rr < n; rr++)
                        begin
                            row = mem[12'(ireg[11:0] + rr)];
                            py = (vy + rr) % 32;
                            for (int b = 0; b < 8; b++)
                            begin
                                if (row[7 - b])
                                begin
                                    px = (vx + b) % 64;
                                    if (fb[py * 64 + px])
                                        f = 1'b1;
                                    fb[py * 64 + px] = ~fb[py * 64 + px];
                                    r.display_changed = 1'b1;
                                end
                            end
                        end
                        vreg[15] = {7'd0, f};
                    end
                    4'hE:
                    begin
                        f = it.key_state[vx[3:0]];
                        if (nn == SK_DOWN)
                        begin
                            if (f) nxt = pc + 12'd4;
                        end
                        else if (nn == SK_UP)
                        begin
                            if (!f) nxt = pc + 12'd4;
                        end
                        else
                            r.bad_opcode = 1'b1;
                    end
                    default:
                    begin
                        case (nn)
                            F_GET_DT: vreg[x] = delay_t;
                            F_WAIT_KEY, F_STORE, F_LOAD: ;
                            F_SET_DT: delay_t = vx;
                            F_SET_ST: sound_t = vx;
                            F_ADD_I: ireg = ireg + {8'd0, vx};
                            F_GLYPH: ireg = {12'd0, vx[3:0]} * 16'd5;
                            F_BCD:
                            begin
                                mem[ireg[11:0]] = vx / 100;
                                mem[12'(ireg[11:0] + 12'd1)] = (vx / 10) % 10;
                                mem[12'(ireg[11:0] + 12'd2)] = vx % 10;
                            end
                            default: r.bad_opcode = 1'b1;
                        endcase
                    end
                endcase
                pc = nxt;
                if (delay_t != 0) delay_t--;
                if (sound_t != 0) sound_t--;
                r.opcode_now = op;
            end
        endcase
        r.pc_now = pc;
        r.sound_on = (sound_t != 0);
        return r;
    endfunction

    task automatic queue_item(item_t it);
        expected_results.push_back(run_core(it));
        pending_items.push_back(it);
        n_items++;
    endtask

    function automatic item_t noise_item(logic [1:0] mode);
        item_t it;
        it.mode = mode;
        it.address = 12'($urandom);
        it.data_byte = 8'($urandom);
        it.key_state = 16'($urandom);
        it.random_byte = 8'($urandom);
        return it;
    endfunction

    // place an instruction at the predicted pc, then run it
    task automatic run_op(logic [15:0] op);
        item_t it;
        it = noise_item(MODE_LOAD);
        it.address = pc;
        it.data_byte = op[15:8];
        queue_item(it);
        it = noise_item(MODE_LOAD);
        it.address = pc + 12'd1;
        it.data_byte = op[7:0];
        queue_item(it);
        queue_item(noise_item(MODE_EXEC));
    endtask

    function automatic logic [15:0] random_op();
        logic [15:0] op;
        op = 16'($urandom);
        case (op[15:12])
            4'h0:
            begin
                case ($urandom_range(3))
                    0: op = OP_CLS;
                    1, 2: op = OP_RET;
                    default: ;
                endcase
            end
            4'h5, 4'h9: if ($urandom_range(3) != 0) op[3:0] = 4'h0;
            4'h8: if ($urandom_range(7) != 0) op[3:0] = 4'($urandom_range(7));
            4'hD: if ($urandom_range(3) != 0) op[3:0] = 4'($urandom_range(4));
            4'hE: if ($urandom_range(3) != 0) op[7:0] = $urandom_range(1) ? SK_DOWN : SK_UP;
            4'hF:
            begin
                case ($urandom_range(9))
                    0: op[7:0] = F_GET_DT;
                    1: op[7:0] = F_WAIT_KEY;
                    2: op[7:0] = F_SET_DT;
                    3: op[7:0] = F_SET_ST;
                    4: op[7:0] = F_ADD_I;
                    5: op[7:0] = F_GLYPH;
                    6: op[7:0] = F_BCD;
                    7: op[7:0] = F_STORE;
                    8: op[7:0] = F_LOAD;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return op;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_start(logic [11:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        pc = value;
    endtask

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("mismatch %s: got %h, expected %h", what, got, want);
    endtask

    // driver
    always @(posedge clk)
        in_taken <= item_valid && item_ready;

    always @(negedge clk)
    begin
        if (!item_valid || in_taken)
        begin
            if (rst_n && pending_items.size() != 0 && (calm || $urandom_range(99) >= 16))
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_req && !hold_done)
        begin
            hold_cnt <= 600;
            hold_done <= 1'b1;
        end
    end

    always @(negedge clk)
        result_ready <= rst_n && hold_cnt == 0 && !(hold_req && !hold_done)
                        && (calm || $urandom_range(99) >= 16);

    // monitor
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report("unexpected transfer", result.opcode_now, 16'h0000);
            end
            else
            begin
                result_t want;
                want = expected_results.pop_front();
                if (result.pc_now != want.pc_now)
                    report("pc_now", 16'(result.pc_now), 16'(want.pc_now));
                if (result.opcode_now != want.opcode_now)
                    report("opcode_now", result.opcode_now, want.opcode_now);
                if (result.display_changed != want.display_changed)
                    report("display_changed", 16'(result.display_changed),
                           16'(want.display_changed));
                if (result.sound_on != want.sound_on)
                    report("sound_on", 16'(result.sound_on), 16'(want.sound_on));
                if (result.bad_opcode != want.bad_opcode)
                    report("bad_opcode", 16'(result.bad_opcode), 16'(want.bad_opcode));
                if (result.read_value != want.read_value)
                    report("read_value", 16'(result.read_value), 16'(want.read_value));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("chip8_instruction_core_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        item_t it;
        logic [11:0] starts [4];
        for (int i = 0; i < 4096; i++)
            mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'd0;
        for (int i = 0; i < 16; i++)
        begin
            vreg[i] = '0;
            ret_stack[i] = '0;
        end
        for (int i = 0; i < 2048; i++)
            fb[i] = 1'b0;
        ireg = '0;
        pc = PC_RESET;
        sp = 0;
        delay_t = TIMER_RESET;
        sound_t = TIMER_RESET;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, reads, corner instructions
        it = noise_item(MODE_READ);
        it.address = 12'd0;
        queue_item(it);
        it.address = 12'hFFF;
        queue_item(it);
        it = noise_item(MODE_LOAD);
        it.address = 12'hFFF;
        it.data_byte = 8'hFF;
        it.key_state = 16'hFFFF;
        it.random_byte = 8'hFF;
        queue_item(it);
        it = noise_item(MODE_PIXEL);
        it.address = 12'hFFF;
        queue_item(it);
        run_op(OP_RET);
        run_op(16'h60FF);
        run_op(16'h61FF);
        run_op(16'h8014);
        run_op(16'hF029);
        run_op(16'hD00F);
        run_op(16'hD005);
        run_op(16'h00E0);
        run_op(16'h5121);
        run_op(16'h812F);
        run_op(16'hE0FF);
        run_op(16'hF1FF);
        run_op(16'h0123);

        starts[0] = 12'h000;
        starts[1] = 12'hFFF;
        starts[2] = PC_RESET;
        starts[3] = 12'($urandom);
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            repeat (60) @(negedge clk);
            set_start(starts[ph]);
            calm = (ph == 2);
            for (int k = 0; k < 105; k++)
            begin
                if (ph == 1 && k == 50)
                    hold_req = 1'b1;
                if (ph == 3 && k == 100)
                    wait_idle();
                if (ph == 0 && k == 60)
                begin
                    // nest calls past the stack depth, then unwind
                    for (int d = 0; d < 17; d++)
                        run_op({4'h2, 12'($urandom)});
                    for (int d = 0; d < 18; d++)
                        run_op(OP_RET);
                end
                if ($urandom_range(9) < 8)
                    run_op(random_op());
                else
                    queue_item(noise_item(2'($urandom)));
            end
        end

        wait_idle();
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("chip8_instruction_core_top regression: pass");
        else
            $display("chip8_instruction_core_top regression: fail");
        $finish;
    end

endmodule
